// ===== hdl/cfd_pkg.sv =====
`default_nettype none

package cfd_pkg;

    localparam int MaxHeaderBytes = 6;
    localparam int LenBytesMax    = MaxHeaderBytes - 1;

    localparam int MaskWidth   = 64;
    localparam int MaxLenWidth = 32;
    localparam int CfgWidth    = 64;
    localparam int CfgIdxWidth = 2;

    localparam logic [CfgIdxWidth-1:0] CFG_KNOWN_MASK = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_MAX_LEN    = 2'd1;

    localparam logic [MaxLenWidth-1:0] MaxLenReset = 32'd4096;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_UNKNOWN   = 2'd2,
        KIND_MALFORMED = 2'd3
    } kind_t;

endpackage

`default_nettype wire

// ===== hdl/command_frame_deframer.sv =====
`default_nettype none

// Command frame deframer. Each input transfer carries one received byte, with tlast marking
// the end of a receive chunk. A frame is a command byte, an LEB128 payload length (up to
// five bytes, low group first) and the payload. Payload bytes leave one per transfer,
// tagged with the command, with tlast on the final byte; a zero length gives one empty
// message. Unknown commands and malformed lengths give one error transfer, after which the
// rest of the chunk is dropped. Every byte passes through the input register, the parsing
// logic and the output register, so one byte is taken in every clock cycle while the
// output side keeps up. The user must write the known_command_mask (index 0) and
// max_payload_len (index 1) registers only while the block is idle; the block itself does
// not enforce this.
module command_frame_deframer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,   // rx_byte
    input  wire logic                           s_axis_tlast,   // chunk_end
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output      logic [15:0]                    m_axis_tdata,   // command [7:0], data [15:8]
    output      logic                           m_axis_tlast,   // last
    output      logic [1:0]                     m_axis_tuser,   // kind
    input  wire logic                           cfg_we,
    input  wire logic [cfd_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [cfd_pkg::CfgWidth-1:0]    cfg_data
);
    import cfd_pkg::*;

    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2,
        PH_DROP = 2'd3
    } phase_t;

    logic [MaskWidth-1:0]   mask_reg;
    logic [MaxLenWidth-1:0] max_len_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [31:0] accum_reg, accum_next;
    logic [2:0] seen_reg, seen_next;
    logic [31:0] left_reg, left_next;

    logic       out_valid_reg, out_valid_next;
    kind_t      out_kind_reg;
    logic [7:0] out_cmd_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    logic       advance;
    logic       res_valid;
    kind_t      res_kind;
    logic [7:0] res_data;
    logic       res_last;
    logic       fail;
    logic [6:0] group;
    logic [31:0] shifted;
    logic [31:0] accum_new;
    logic [31:0] left_dec;
    logic [2:0] seen_inc;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg, out_cmd_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_kind_reg;

    assign group     = in_byte_reg[6:0];
    assign accum_new = accum_reg | shifted;
    assign left_dec  = (left_reg != 32'd0) ? left_reg - 32'd1 : 32'd0;
    assign seen_inc  = seen_reg + 3'd1;

    always_comb
    begin
        case (seen_reg)
            3'd0:    shifted = {25'd0, group};
            3'd1:    shifted = {18'd0, group, 7'd0};
            3'd2:    shifted = {11'd0, group, 14'd0};
            3'd3:    shifted = {4'd0, group, 21'd0};
            3'd4:    shifted = {group[3:0], 28'd0};
            default: shifted = 32'd0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        accum_next = accum_reg;
        seen_next  = seen_reg;
        left_next  = left_reg;
        res_valid  = 1'b0;
        res_kind   = KIND_PAYLOAD;
        res_data   = 8'd0;
        res_last   = 1'b1;
        fail       = 1'b0;

        case (phase_reg)
            PH_CMD:
            begin
                held_next  = in_byte_reg;
                accum_next = 32'd0;
                seen_next  = 3'd0;
                if (in_byte_reg[7:6] != 2'd0 || !mask_reg[in_byte_reg[5:0]])
                begin
                    fail     = 1'b1;
                    res_kind = KIND_UNKNOWN;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (seen_reg >= 3'(LenBytesMax))
                begin
                    fail     = 1'b1;
                    res_kind = KIND_MALFORMED;
                end
                else if (seen_reg == 3'(LenBytesMax - 1) && group > 7'd15)
                begin
                    fail     = 1'b1;
                    res_kind = KIND_MALFORMED;
                end
                else
                begin
                    accum_next = accum_new;
                    seen_next  = seen_inc;
                    if (in_byte_reg[7])
                    begin
                        if (seen_inc >= 3'(LenBytesMax))
                        begin
                            fail     = 1'b1;
                            res_kind = KIND_MALFORMED;
                        end
                    end
                    else if (accum_new > max_len_reg)
                    begin
                        fail     = 1'b1;
                        res_kind = KIND_MALFORMED;
                    end
                    else if (accum_new == 32'd0)
                    begin
                        res_valid  = 1'b1;
                        res_kind   = KIND_EMPTY;
                        phase_next = PH_CMD;
                        seen_next  = 3'd0;
                    end
                    else
                    begin
                        left_next  = accum_new;
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                left_next = left_dec;
                res_valid = 1'b1;
                res_kind  = KIND_PAYLOAD;
                res_data  = in_byte_reg;
                res_last  = (left_dec == 32'd0);
                if (left_dec == 32'd0)
                begin
                    phase_next = PH_CMD;
                    accum_next = 32'd0;
                    seen_next  = 3'd0;
                end
            end
            PH_DROP:
            begin
                if (in_end_reg)
                begin
                    phase_next = PH_CMD;
                end
            end
            default:
            begin
                phase_next = PH_CMD;
            end
        endcase

        if (fail)
        begin
            res_valid  = 1'b1;
            res_data   = 8'd0;
            res_last   = 1'b1;
            phase_next = in_end_reg ? PH_CMD : PH_DROP;
            accum_next = 32'd0;
            seen_next  = 3'd0;
            left_next  = 32'd0;
        end
    end

    assign out_valid_next = advance ? res_valid : (out_valid_reg && !m_axis_tready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '1;
            max_len_reg <= MaxLenReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KNOWN_MASK: mask_reg    <= cfg_data;
                CFG_MAX_LEN:    max_len_reg <= cfg_data[MaxLenWidth-1:0];
                default:        ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CMD;
            held_reg  <= 8'd0;
            accum_reg <= 32'd0;
            seen_reg  <= 3'd0;
            left_reg  <= 32'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            accum_reg <= accum_next;
            seen_reg  <= seen_next;
            left_reg  <= left_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_cmd_reg  <= held_next;
            out_data_reg <= res_data;
            out_last_reg <= res_last;
        end
    end

    a_pay_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAY |-> left_reg != 32'd0)
        else $error("payload phase with no bytes left");

    a_len_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= 3'(LenBytesMax))
        else $error("length byte count out of range");

    a_nonpayload_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg != KIND_PAYLOAD |-> out_last_reg && out_data_reg == 8'd0)
        else $error("non-payload result without last or with data");

    a_len_to_payload: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_LEN && phase_next == PH_PAY |=> left_reg == accum_reg)
        else $error("payload count not loaded from length");

endmodule

`default_nettype wire
